// File: rtl/core/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants of the PSI section reassembler.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int LENGTH_BITS = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] STUFF_BYTE = 8'hFF;

    localparam logic       KIND_DATA  = 1'b0;
    localparam logic       KIND_ABORT = 1'b1;

    localparam logic [1:0] ROLE_HEADER = 2'd0;
    localparam logic [1:0] ROLE_BODY   = 2'd1;
    localparam logic [1:0] ROLE_CRC    = 2'd2;

    // One classified transaction handed from the front part to the back part.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] role;
        logic [9:0] offset;
        logic       last;
    } psr_result_t;

endpackage

// File: rtl/core/psr_front.sv
// ----------------------------------------------------------------------------
// psr_front
// Tracks sync, pointer field and section header; classifies each section data byte.
// ----------------------------------------------------------------------------
module psr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          payload_byte,
    input  logic                packet_start,
    input  logic                unit_start,
    input  logic [3:0]          cont_counter,
    input  logic                take,
    output logic                res_valid,
    output psr_pkg::psr_result_t res
);
    import psr_pkg::*;

    typedef enum logic [2:0] {
        PH_AWAIT = 3'd0,
        PH_HI    = 3'd1,
        PH_LO    = 3'd2,
        PH_DATA  = 3'd3,
        PH_STUFF = 3'd4
    } phase_t;

    logic                   sync_reg, sync_next;
    logic [3:0]             exp_reg, exp_next;
    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [7:0]             ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;

    logic                   go;
    logic                   emit;
    logic [LENGTH_BITS-1:0] off;
    logic [LENGTH_BITS-1:0] new_len;
    logic [1:0]             role;

    always_comb
    begin
        off     = len_reg - left_reg;
        new_len = len_reg | LENGTH_BITS'(payload_byte);
        if (off < LENGTH_BITS'(5))
            role = ROLE_HEADER;
        else if (len_reg >= LENGTH_BITS'(4) && off >= len_reg - LENGTH_BITS'(4))
            role = ROLE_CRC;
        else
            role = ROLE_BODY;
    end

    always_comb
    begin
        sync_next  = sync_reg;
        exp_next   = exp_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        ptr_next   = ptr_reg;
        pend_next  = pend_reg;
        res_valid  = 1'b0;
        res        = '0;
        emit       = 1'b0;
        go         = 1'b0;
        if (take) begin
            if (packet_start && unit_start) begin
                sync_next = 1'b1;
                exp_next  = cont_counter + 4'd1;
                ptr_next  = payload_byte;
                if (!pend_reg)
                    phase_next = PH_AWAIT;
            end else if (packet_start && sync_reg) begin
                if (cont_counter != exp_reg) begin
                    sync_next  = 1'b0;
                    phase_next = PH_AWAIT;
                    len_next   = '0;
                    left_next  = '0;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    if (pend_reg) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ABORT;
                    end
                end else begin
                    exp_next = cont_counter + 4'd1;
                    go       = 1'b1;
                end
            end else if (!packet_start && sync_reg) begin
                go = 1'b1;
            end
        end
        if (go) begin
            // stuffing ends at the packet boundary
            if (packet_start && phase_reg == PH_STUFF)
                phase_next = PH_AWAIT;
            if (ptr_reg != 8'd0) begin
                ptr_next = ptr_reg - 8'd1;
                emit     = pend_reg && left_reg != '0;
            end else begin
                case (phase_next)
                    PH_AWAIT: phase_next = (payload_byte == STUFF_BYTE) ? PH_STUFF : PH_HI;
                    PH_HI:
                    begin
                        len_next   = LENGTH_BITS'({payload_byte, 8'd0});
                        phase_next = PH_LO;
                    end
                    PH_LO:
                    begin
                        len_next = new_len;
                        if (new_len == '0)
                            phase_next = PH_AWAIT;
                        else begin
                            left_next  = new_len;
                            pend_next  = 1'b1;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (pend_reg && left_reg != '0)
                            emit = 1'b1;
                        else
                            phase_next = PH_AWAIT;
                    end
                    PH_STUFF: phase_next = PH_STUFF;
                    default:  phase_next = PH_AWAIT;
                endcase
            end
        end
        if (emit) begin
            res_valid  = 1'b1;
            res.kind   = KIND_DATA;
            res.data   = payload_byte;
            res.role   = role;
            res.offset = 10'(off);
            res.last   = (left_reg == LENGTH_BITS'(1));
            left_next  = left_reg - LENGTH_BITS'(1);
            if (left_reg == LENGTH_BITS'(1)) begin
                pend_next  = 1'b0;
                phase_next = PH_AWAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_reg  <= 1'b0;
            exp_reg   <= '0;
            phase_reg <= PH_AWAIT;
            len_reg   <= '0;
            left_reg  <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            sync_reg  <= sync_next;
            exp_reg   <= exp_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// File: rtl/core/psr_queue.sv
// ----------------------------------------------------------------------------
// psr_queue
// Small FIFO of classified results between the front and back parts.
// ----------------------------------------------------------------------------
module psr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  psr_pkg::psr_result_t wr_data,
    output logic                 full,
    output logic                 rd_valid,
    input  logic                 rd_en,
    output psr_pkg::psr_result_t rd_data
);
    import psr_pkg::*;

    psr_result_t         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [QUEUE_AW:0]   cnt_reg;

    assign full     = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en)
                wp_reg <= wp_reg + QUEUE_AW'(1);
            if (rd_en)
                rp_reg <= rp_reg + QUEUE_AW'(1);
            cnt_reg <= cnt_reg + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
        end
    end

endmodule

// File: rtl/core/psr_back.sv
// ----------------------------------------------------------------------------
// psr_back
// Output register stage: presents queued results on the output channel.
// ----------------------------------------------------------------------------
module psr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  psr_pkg::psr_result_t q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output psr_pkg::psr_result_t out_data
);
    import psr_pkg::*;

    logic        valid_reg;
    psr_result_t data_reg;

    // refill when empty or when the held transaction leaves
    assign q_pop     = q_valid && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

endmodule

// File: rtl/core/psi_section_reassembler.sv
// ----------------------------------------------------------------------------
// psi_section_reassembler
// Reassembles PSI sections from transport stream payload bytes.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   payload_byte packet_start unit_start
//                                         cont_counter
// out      output     out_valid/out_stall kind section_byte byte_role
//                                         byte_offset last_of_section
// One byte is taken per cycle while in_stall is low; the front updates its parse state in that cycle.
// A result is written to the queue at the edge that takes its byte and reaches the
// output through the output register.
// in_stall rises only when the four-entry result queue is full.
// Reset clears sync, parse state, queue and output register.
// ----------------------------------------------------------------------------
module psi_section_reassembler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] payload_byte,
    input  logic       packet_start,
    input  logic       unit_start,
    input  logic [3:0] cont_counter,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] section_byte,
    output logic [1:0] byte_role,
    output logic [9:0] byte_offset,
    output logic       last_of_section
);
    import psr_pkg::*;

    logic        take, q_full, f_valid, q_valid, q_pop;
    psr_result_t f_res, q_data, o_data;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    psr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .payload_byte (payload_byte),
        .packet_start (packet_start),
        .unit_start   (unit_start),
        .cont_counter (cont_counter),
        .take         (take),
        .res_valid    (f_valid),
        .res          (f_res)
    );

    psr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_valid),
        .wr_data  (f_res),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_data  (q_data)
    );

    psr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (o_data)
    );

    assign kind            = o_data.kind;
    assign section_byte    = o_data.data;
    assign byte_role       = o_data.role;
    assign byte_offset     = o_data.offset;
    assign last_of_section = o_data.last;

endmodule
